FILE: sv/frame_difference_motion_centroid_top_defines.svh
// ---------------------------------------------------------------------------
// Frame difference motion centroid: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_MOTION_CENTROID_TOP_DEFINES_SVH
`define FRAME_DIFFERENCE_MOTION_CENTROID_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDMC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/fdmc_pkg.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: shared package
// Widths, register indexes and the types passed between the front end,
// the queue and the back end.
// ---------------------------------------------------------------------------
package fdmc_pkg;

	localparam int COORD_BITS  = 11;
	localparam int PIX_W       = 11;
	localparam int COORD_USE   = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam int SUM_W       = COORD_BITS + 22;
	localparam int COUNT_W     = 23;
	localparam int COLOR_W     = 8;
	localparam int DIST_W      = 2 * COLOR_W + 2;
	localparam int THR_W       = 9;
	localparam int THRSQ_W     = 2 * THR_W;
	localparam int CFG_W       = 23;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

	localparam logic REG_COLOR_THRESHOLD = 1'b0;
	localparam logic REG_MIN_MOTION      = 1'b1;

	typedef struct packed {
		logic                 motion;
		logic                 last;
		logic [COORD_USE-1:0] x;
		logic [COORD_USE-1:0] y;
	} pix_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: sv/frame_difference_motion_centroid_top.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: top level
// Marks pixels whose color changed beyond a threshold since the previous
// frame and reports the centroid of the marked pixels at each frame end.
//
//   Channel  Direction  Handshake                Carries
//   in       input      in_valid / in_ready      current and previous color,
//                                                coordinates, frame end mark
//   out      output     out_valid / out_ready    motion flag, frame result
//   cfg      input      cfg_we (write only)      threshold, minimum count
//
// An ordinary pixel passes from the front-end stage register through the
// queue to the back end's result registers. A frame's last pixel with a
// centroid holds the back end while the bit-serial divider runs; the
// four-entry queue keeps the front end taking pixels meanwhile. Reset
// clears control state and loads the register defaults; no clearing
// pass. A stalled output holds its result while the queue keeps
// filling.
// ---------------------------------------------------------------------------
module frame_difference_motion_centroid_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_red,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_green,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_blue,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_red,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_green,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_blue,
	input  logic [fdmc_pkg::PIX_W-1:0]    pix_x,
	input  logic [fdmc_pkg::PIX_W-1:0]    pix_y,
	input  logic                          frame_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          motion,
	output logic                          frame_done,
	output logic                          centroid_found,
	output logic [fdmc_pkg::PIX_W-1:0]    centroid_x,
	output logic [fdmc_pkg::PIX_W-1:0]    centroid_y,
	output logic [fdmc_pkg::COUNT_W-1:0]  motion_total,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [fdmc_pkg::CFG_W-1:0]    cfg_data
);

	logic [fdmc_pkg::THR_W-1:0]   threshold_q;
	logic [fdmc_pkg::COUNT_W-1:0] min_motion_q;

	logic                         push, pop;
	fdmc_pkg::pix_t               push_data, head;
	fdmc_pkg::qstat_t             qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= fdmc_pkg::THR_W'(50);
			min_motion_q <= fdmc_pkg::COUNT_W'(200);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdmc_pkg::REG_COLOR_THRESHOLD: begin
					threshold_q <= cfg_data[fdmc_pkg::THR_W-1:0];
				end
				fdmc_pkg::REG_MIN_MOTION: begin
					min_motion_q <= cfg_data[fdmc_pkg::COUNT_W-1:0];
				end
			endcase
		end
	end

	fdmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cur_red    (cur_red),
		.cur_green  (cur_green),
		.cur_blue   (cur_blue),
		.prev_red   (prev_red),
		.prev_green (prev_green),
		.prev_blue  (prev_blue),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.frame_last (frame_last),
		.threshold  (threshold_q),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	fdmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	fdmc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.qstat          (qstat),
		.pop            (pop),
		.min_motion     (min_motion_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motion         (motion),
		.frame_done     (frame_done),
		.centroid_found (centroid_found),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.motion_total   (motion_total)
	);

endmodule

FILE: sv/fdmc_front.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: front end
// Takes pixels, forms the squared color distance, classifies each pixel
// as motion or still and pushes it into the queue.
// ---------------------------------------------------------------------------
module fdmc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_red,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_green,
	input  logic [fdmc_pkg::COLOR_W-1:0]  cur_blue,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_red,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_green,
	input  logic [fdmc_pkg::COLOR_W-1:0]  prev_blue,
	input  logic [fdmc_pkg::PIX_W-1:0]    pix_x,
	input  logic [fdmc_pkg::PIX_W-1:0]    pix_y,
	input  logic                          frame_last,
	input  logic [fdmc_pkg::THR_W-1:0]    threshold,
	input  fdmc_pkg::qstat_t              qstat,
	output logic                          push,
	output fdmc_pkg::pix_t                push_data
);

	logic [fdmc_pkg::COLOR_W-1:0]         dr, dg, db;
	logic [2*fdmc_pkg::COLOR_W-1:0]       sr, sg, sb;
	logic [fdmc_pkg::DIST_W-1:0]          color_dist;
	logic                                 accept;

	logic                                 valid_s1;
	logic [fdmc_pkg::DIST_W-1:0]          color_dist_s1;
	logic                                 last_s1;
	logic [fdmc_pkg::COORD_USE-1:0]       x_s1, y_s1;
	logic [fdmc_pkg::THRSQ_W-1:0]         thr_sq_q;

	always_comb begin
		dr = (cur_red >= prev_red) ? cur_red - prev_red : prev_red - cur_red;
		dg = (cur_green >= prev_green) ? cur_green - prev_green : prev_green - cur_green;
		db = (cur_blue >= prev_blue) ? cur_blue - prev_blue : prev_blue - cur_blue;
		sr = dr * dr;
		sg = dg * dg;
		sb = db * db;
		color_dist = fdmc_pkg::DIST_W'(sr) + fdmc_pkg::DIST_W'(sg) + fdmc_pkg::DIST_W'(sb);
	end

	assign in_ready = !valid_s1 || !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && !qstat.full;

	always_comb begin
		push_data.motion = fdmc_pkg::THRSQ_W'(color_dist_s1) > thr_sq_q;
		push_data.last   = last_s1;
		push_data.x      = x_s1;
		push_data.y      = y_s1;
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= threshold * threshold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			color_dist_s1 <= color_dist;
			last_s1       <= frame_last;
			x_s1          <= pix_x[fdmc_pkg::COORD_USE-1:0];
			y_s1          <= pix_y[fdmc_pkg::COORD_USE-1:0];
		end
	end

endmodule

FILE: sv/fdmc_queue.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: pixel queue
// Short first-in first-out buffer of classified pixels between the front
// end and the back end.
// ---------------------------------------------------------------------------
module fdmc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fdmc_pkg::pix_t   push_data,
	input  logic             pop,
	output fdmc_pkg::pix_t   head,
	output fdmc_pkg::qstat_t qstat
);

	fdmc_pkg::pix_t                 entry_q [fdmc_pkg::QUEUE_DEPTH];
	logic [fdmc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [fdmc_pkg::QCNT_W-1:0]    count_q;

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == fdmc_pkg::QCNT_W'(fdmc_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/fdmc_back.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: back end
// Accumulates motion coordinates, divides both sums by the count at frame
// end with a paired bit-serial divider, and holds the result register.
// ---------------------------------------------------------------------------
module fdmc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdmc_pkg::pix_t                head,
	input  fdmc_pkg::qstat_t              qstat,
	output logic                          pop,
	input  logic [fdmc_pkg::COUNT_W-1:0]  min_motion,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          motion,
	output logic                          frame_done,
	output logic                          centroid_found,
	output logic [fdmc_pkg::PIX_W-1:0]    centroid_x,
	output logic [fdmc_pkg::PIX_W-1:0]    centroid_y,
	output logic [fdmc_pkg::COUNT_W-1:0]  motion_total
);

	localparam int SW = fdmc_pkg::SUM_W;
	localparam int CW = fdmc_pkg::COUNT_W;
	localparam logic [SW-1:0] COORD_MAX =
		{{(SW - fdmc_pkg::COORD_BITS){1'b0}}, {fdmc_pkg::COORD_BITS{1'b1}}};

	typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_OUT} state_t;

	state_t                         state_q;
	logic                           out_valid_q;
	logic [SW-1:0]                  sum_cols_q, sum_rows_q;
	logic [CW-1:0]                  count_q;
	logic [SW-1:0]                  num_x_q, num_y_q;
	logic [CW:0]                    rem_x_q, rem_y_q;
	logic [CW-1:0]                  den_q;
	logic                           motion_hold_q;
	logic [fdmc_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic                           out_free;
	logic [SW:0]                    add_cols, add_rows;
	logic [CW:0]                    add_count;
	logic [SW-1:0]                  new_cols, new_rows;
	logic [CW-1:0]                  new_count;
	logic [CW:0]                    rsh_x, rsh_y;
	logic                           ge_x, ge_y;
	logic [SW-1:0]                  qx, qy;
	logic                           go_div;
	logic                           load_out;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_RUN) && !qstat.empty && out_free;
	assign out_valid = out_valid_q;
	assign go_div    = pop && head.last && (new_count > min_motion);
	assign load_out  = (pop && !go_div) || ((state_q == ST_OUT) && out_free);

	always_comb begin
		add_cols  = {1'b0, sum_cols_q} + (SW+1)'(head.x);
		add_rows  = {1'b0, sum_rows_q} + (SW+1)'(head.y);
		add_count = {1'b0, count_q} + 1'b1;
		new_cols  = sum_cols_q;
		new_rows  = sum_rows_q;
		new_count = count_q;
		if (head.motion) begin
			new_cols  = add_cols[SW] ? {SW{1'b1}} : add_cols[SW-1:0];
			new_rows  = add_rows[SW] ? {SW{1'b1}} : add_rows[SW-1:0];
			new_count = add_count[CW] ? {CW{1'b1}} : add_count[CW-1:0];
		end
	end

	always_comb begin
		rsh_x = {rem_x_q[CW-1:0], num_x_q[SW-1]};
		rsh_y = {rem_y_q[CW-1:0], num_y_q[SW-1]};
		ge_x  = rsh_x >= {1'b0, den_q};
		ge_y  = rsh_y >= {1'b0, den_q};
		qx    = (num_x_q > COORD_MAX) ? COORD_MAX : num_x_q;
		qy    = (num_y_q > COORD_MAX) ? COORD_MAX : num_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			out_valid_q    <= 1'b0;
			sum_cols_q     <= '0;
			sum_rows_q     <= '0;
			count_q        <= '0;
			div_cnt_q      <= '0;
			num_x_q        <= '0;
			num_y_q        <= '0;
			rem_x_q        <= '0;
			rem_y_q        <= '0;
			den_q          <= '0;
			motion_hold_q  <= 1'b0;
			motion         <= 1'b0;
			frame_done     <= 1'b0;
			centroid_found <= 1'b0;
			centroid_x     <= '0;
			centroid_y     <= '0;
			motion_total   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (!head.last) begin
							sum_cols_q     <= new_cols;
							sum_rows_q     <= new_rows;
							count_q        <= new_count;
							motion         <= head.motion;
							frame_done     <= 1'b0;
							centroid_found <= 1'b0;
							centroid_x     <= '0;
							centroid_y     <= '0;
							motion_total   <= '0;
						end else begin
							sum_cols_q <= '0;
							sum_rows_q <= '0;
							count_q    <= '0;
							if (go_div) begin
								num_x_q       <= new_cols;
								num_y_q       <= new_rows;
								rem_x_q       <= '0;
								rem_y_q       <= '0;
								den_q         <= new_count;
								motion_hold_q <= head.motion;
								div_cnt_q     <= fdmc_pkg::DIV_CNT_W'(SW);
								state_q       <= ST_DIV;
							end else begin
								motion         <= head.motion;
								frame_done     <= 1'b1;
								centroid_found <= 1'b0;
								centroid_x     <= '0;
								centroid_y     <= '0;
								motion_total   <= new_count;
							end
						end
					end
				end
				ST_DIV: begin
					rem_x_q   <= ge_x ? rsh_x - {1'b0, den_q} : rsh_x;
					rem_y_q   <= ge_y ? rsh_y - {1'b0, den_q} : rsh_y;
					num_x_q   <= {num_x_q[SW-2:0], ge_x};
					num_y_q   <= {num_y_q[SW-2:0], ge_y};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == fdmc_pkg::DIV_CNT_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						motion         <= motion_hold_q;
						frame_done     <= 1'b1;
						centroid_found <= 1'b1;
						centroid_x     <= qx[fdmc_pkg::PIX_W-1:0];
						centroid_y     <= qy[fdmc_pkg::PIX_W-1:0];
						motion_total   <= den_q;
						state_q        <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

FILE: sv/fdmc_checker.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: port checker
// Watches the top level's ports for consistent result fields and a held
// output while it is stalled.
// ---------------------------------------------------------------------------
`include "frame_difference_motion_centroid_top_defines.svh"

module fdmc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          motion,
	input logic                          frame_done,
	input logic                          centroid_found,
	input logic [fdmc_pkg::PIX_W-1:0]    centroid_x,
	input logic [fdmc_pkg::PIX_W-1:0]    centroid_y,
	input logic [fdmc_pkg::COUNT_W-1:0]  motion_total
);

	`FDMC_ASSERT_SAME(a_mid_frame_quiet, out_valid && !frame_done, !centroid_found && centroid_x == '0 && centroid_y == '0 && motion_total == '0, "Mid-frame result carries frame fields.")

	`FDMC_ASSERT_SAME(a_no_centroid_zero, out_valid && !centroid_found, centroid_x == '0 && centroid_y == '0, "Centroid given without enough motion.")

	`FDMC_ASSERT_SAME(a_found_has_count, out_valid && centroid_found, frame_done && motion_total != '0, "Centroid found with an empty count.")

	`FDMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(motion) && $stable(frame_done) && $stable(centroid_x) && $stable(centroid_y) && $stable(motion_total), "Stalled result changed.")

endmodule

bind frame_difference_motion_centroid_top fdmc_checker u_fdmc_checker (.*);

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Frame difference motion centroid: testbench
// Drives pixel requests through the valid/ready input channel and checks
// every result against a cycle-free predictor of the motion test, the
// saturating accumulators and the end-of-frame centroid. A directed table
// covers the field extremes and threshold boundaries, then randomized
// frames run under several register settings with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int CYCLE_LIMIT     = 900000;
	localparam int MIN_EXTREME     = 4194304;
	localparam int THR_EXTREME     = 442;
	localparam logic [fdmc_pkg::SUM_W-1:0] COORD_LIMIT =
		(fdmc_pkg::SUM_W'(1) << fdmc_pkg::COORD_BITS) - fdmc_pkg::SUM_W'(1);

	typedef struct packed {
		logic [fdmc_pkg::COLOR_W-1:0] cur_r;
		logic [fdmc_pkg::COLOR_W-1:0] cur_g;
		logic [fdmc_pkg::COLOR_W-1:0] cur_b;
		logic [fdmc_pkg::COLOR_W-1:0] prev_r;
		logic [fdmc_pkg::COLOR_W-1:0] prev_g;
		logic [fdmc_pkg::COLOR_W-1:0] prev_b;
		logic [fdmc_pkg::PIX_W-1:0]   x;
		logic [fdmc_pkg::PIX_W-1:0]   y;
		logic                         last;
	} pix_req_t;

	typedef struct packed {
		logic                         motion;
		logic                         done;
		logic                         found;
		logic [fdmc_pkg::PIX_W-1:0]   cx;
		logic [fdmc_pkg::PIX_W-1:0]   cy;
		logic [fdmc_pkg::COUNT_W-1:0] total;
	} pix_result_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic                       idx;
		logic [fdmc_pkg::CFG_W-1:0] data;
		pix_req_t                   req;
		bit                         typed;
		pix_result_t                want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fdmc_pkg::COLOR_W-1:0] cur_red = '0;
	logic [fdmc_pkg::COLOR_W-1:0] cur_green = '0;
	logic [fdmc_pkg::COLOR_W-1:0] cur_blue = '0;
	logic [fdmc_pkg::COLOR_W-1:0] prev_red = '0;
	logic [fdmc_pkg::COLOR_W-1:0] prev_green = '0;
	logic [fdmc_pkg::COLOR_W-1:0] prev_blue = '0;
	logic [fdmc_pkg::PIX_W-1:0] pix_x = '0;
	logic [fdmc_pkg::PIX_W-1:0] pix_y = '0;
	logic frame_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic motion;
	logic frame_done;
	logic centroid_found;
	logic [fdmc_pkg::PIX_W-1:0] centroid_x;
	logic [fdmc_pkg::PIX_W-1:0] centroid_y;
	logic [fdmc_pkg::COUNT_W-1:0] motion_total;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [fdmc_pkg::CFG_W-1:0] cfg_data = '0;

	logic [fdmc_pkg::THR_W-1:0]   thr_reg;
	logic [fdmc_pkg::COUNT_W-1:0] min_reg;
	logic [fdmc_pkg::SUM_W-1:0]   sum_cols;
	logic [fdmc_pkg::SUM_W-1:0]   sum_rows;
	logic [fdmc_pkg::COUNT_W-1:0] motion_count;

	pix_result_t pending_results[$];
	stim_row_t   stim_table[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          ready_hold = 0;

	frame_difference_motion_centroid_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cur_red       (cur_red),
		.cur_green     (cur_green),
		.cur_blue      (cur_blue),
		.prev_red      (prev_red),
		.prev_green    (prev_green),
		.prev_blue     (prev_blue),
		.pix_x         (pix_x),
		.pix_y         (pix_y),
		.frame_last    (frame_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.motion        (motion),
		.frame_done    (frame_done),
		.centroid_found(centroid_found),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.motion_total  (motion_total),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void reset_motion_state();
		thr_reg      = fdmc_pkg::THR_W'(50);
		min_reg      = fdmc_pkg::COUNT_W'(200);
		sum_cols     = '0;
		sum_rows     = '0;
		motion_count = '0;
	endfunction

	function automatic logic [fdmc_pkg::DIST_W-1:0] sq_dist(
			input logic [fdmc_pkg::COLOR_W-1:0] a, input logic [fdmc_pkg::COLOR_W-1:0] b);
		logic [fdmc_pkg::COLOR_W-1:0] d8;
		logic [fdmc_pkg::DIST_W-1:0]  d;
		d8 = (a >= b) ? a - b : b - a;
		d = fdmc_pkg::DIST_W'(d8);
		return d * d;
	endfunction

	function automatic pix_result_t predict_motion_result(input pix_req_t r);
		pix_result_t                  res;
		logic [fdmc_pkg::DIST_W-1:0]  color_dist;
		logic [fdmc_pkg::THRSQ_W-1:0] thr_wide;
		logic [fdmc_pkg::THRSQ_W-1:0] thr_sq;
		logic [fdmc_pkg::SUM_W:0]     sx;
		logic [fdmc_pkg::SUM_W:0]     sy;
		logic [fdmc_pkg::COUNT_W:0]   cnt;
		logic [fdmc_pkg::SUM_W-1:0]   qx;
		logic [fdmc_pkg::SUM_W-1:0]   qy;
		color_dist = sq_dist(r.cur_r, r.prev_r) + sq_dist(r.cur_g, r.prev_g)
			+ sq_dist(r.cur_b, r.prev_b);
		thr_wide = fdmc_pkg::THRSQ_W'(thr_reg);
		thr_sq = thr_wide * thr_wide;
		res = '0;
		res.motion = fdmc_pkg::THRSQ_W'(color_dist) > thr_sq;
		res.done = r.last;
		if (res.motion) begin
			sx = {1'b0, sum_cols}
				+ (fdmc_pkg::SUM_W+1)'(r.x[fdmc_pkg::COORD_USE-1:0]);
			sum_cols = sx[fdmc_pkg::SUM_W] ? '1 : sx[fdmc_pkg::SUM_W-1:0];
			sy = {1'b0, sum_rows}
				+ (fdmc_pkg::SUM_W+1)'(r.y[fdmc_pkg::COORD_USE-1:0]);
			sum_rows = sy[fdmc_pkg::SUM_W] ? '1 : sy[fdmc_pkg::SUM_W-1:0];
			cnt = {1'b0, motion_count} + 1'b1;
			motion_count = cnt[fdmc_pkg::COUNT_W] ? '1 : cnt[fdmc_pkg::COUNT_W-1:0];
		end
		if (r.last) begin
			res.total = motion_count;
			if (motion_count > min_reg) begin
				res.found = 1'b1;
				qx = sum_cols / fdmc_pkg::SUM_W'(motion_count);
				qy = sum_rows / fdmc_pkg::SUM_W'(motion_count);
				res.cx = (qx > COORD_LIMIT) ? COORD_LIMIT[fdmc_pkg::PIX_W-1:0]
					: qx[fdmc_pkg::PIX_W-1:0];
				res.cy = (qy > COORD_LIMIT) ? COORD_LIMIT[fdmc_pkg::PIX_W-1:0]
					: qy[fdmc_pkg::PIX_W-1:0];
			end
			sum_cols = '0;
			sum_rows = '0;
			motion_count = '0;
		end
		return res;
	endfunction

	function automatic pix_req_t px(input int cr, input int cg, input int cb, input int pr,
			input int pg, input int pb, input int x, input int y, input bit last);
		pix_req_t r;
		r.cur_r  = fdmc_pkg::COLOR_W'(cr);
		r.cur_g  = fdmc_pkg::COLOR_W'(cg);
		r.cur_b  = fdmc_pkg::COLOR_W'(cb);
		r.prev_r = fdmc_pkg::COLOR_W'(pr);
		r.prev_g = fdmc_pkg::COLOR_W'(pg);
		r.prev_b = fdmc_pkg::COLOR_W'(pb);
		r.x      = fdmc_pkg::PIX_W'(x);
		r.y      = fdmc_pkg::PIX_W'(y);
		r.last   = last;
		return r;
	endfunction

	function automatic pix_result_t rs(input bit m, input bit d, input bit f, input int cx,
			input int cy, input int t);
		pix_result_t w;
		w.motion = m;
		w.done   = d;
		w.found  = f;
		w.cx     = fdmc_pkg::PIX_W'(cx);
		w.cy     = fdmc_pkg::PIX_W'(cy);
		w.total  = fdmc_pkg::COUNT_W'(t);
		return w;
	endfunction

	function automatic logic [fdmc_pkg::COLOR_W-1:0] nudge(
			input logic [fdmc_pkg::COLOR_W-1:0] c, input int d);
		int v;
		v = ($urandom_range(0, 1) != 0) ? int'(c) + d : int'(c) - d;
		if (v > 255)
			v = int'(c) - d;
		if (v < 0)
			v = 0;
		return fdmc_pkg::COLOR_W'(v);
	endfunction

	function automatic logic [fdmc_pkg::PIX_W-1:0] random_coord();
		int pick;
		pick = int'($urandom_range(0, 7));
		if (pick == 0)
			return '1;
		else if (pick == 1)
			return '0;
		return fdmc_pkg::PIX_W'($urandom_range(0, 2047));
	endfunction

	function automatic pix_req_t random_pixel(input bit last);
		pix_req_t r;
		int       mode;
		int       span;
		r.cur_r = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
		r.cur_g = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
		r.cur_b = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
		mode = int'($urandom_range(0, 5));
		span = (int'(thr_reg) * 8) / 10 + 1;
		if (mode < 1) begin
			r.prev_r = r.cur_r;
			r.prev_g = r.cur_g;
			r.prev_b = r.cur_b;
		end else if (mode < 4) begin
			r.prev_r = nudge(r.cur_r, int'($urandom_range(0, span)));
			r.prev_g = nudge(r.cur_g, int'($urandom_range(0, span)));
			r.prev_b = nudge(r.cur_b, int'($urandom_range(0, span)));
		end else begin
			r.prev_r = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
			r.prev_g = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
			r.prev_b = fdmc_pkg::COLOR_W'($urandom_range(0, 255));
		end
		r.x = random_coord();
		r.y = random_coord();
		r.last = last;
		return r;
	endfunction

	function automatic int pick_gap();
		int pick;
		pick = int'($urandom_range(0, 99));
		if (pick < 65)
			return 0;
		else if (pick < 90)
			return int'($urandom_range(1, 3));
		else if (pick < 97)
			return int'($urandom_range(4, 10));
		return int'($urandom_range(20, 60));
	endfunction

	task automatic add_pixel(input pix_req_t r);
		stim_row_t row;
		row.kind  = ROW_PIXEL;
		row.idx   = fdmc_pkg::REG_COLOR_THRESHOLD;
		row.data  = '0;
		row.req   = r;
		row.typed = 1'b0;
		row.want  = '0;
		stim_table.push_back(row);
	endtask

	task automatic add_checked(input pix_req_t r, input pix_result_t w);
		stim_row_t row;
		row.kind  = ROW_PIXEL;
		row.idx   = fdmc_pkg::REG_COLOR_THRESHOLD;
		row.data  = '0;
		row.req   = r;
		row.typed = 1'b1;
		row.want  = w;
		stim_table.push_back(row);
	endtask

	task automatic add_write(input logic idx, input int data);
		stim_row_t row;
		row.kind  = ROW_WRITE;
		row.idx   = idx;
		row.data  = fdmc_pkg::CFG_W'(data);
		row.req   = '0;
		row.typed = 1'b0;
		row.want  = '0;
		stim_table.push_back(row);
	endtask

	task automatic drive_request(input pix_req_t r, input bit typed, input pix_result_t want);
		pix_result_t pred;
		in_valid   <= 1'b1;
		cur_red    <= r.cur_r;
		cur_green  <= r.cur_g;
		cur_blue   <= r.cur_b;
		prev_red   <= r.prev_r;
		prev_green <= r.prev_g;
		prev_blue  <= r.prev_b;
		pix_x      <= r.x;
		pix_y      <= r.y;
		frame_last <= r.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_motion_result(r);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [fdmc_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == fdmc_pkg::REG_COLOR_THRESHOLD)
			thr_reg = data[fdmc_pkg::THR_W-1:0];
		else
			min_reg = data[fdmc_pkg::COUNT_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (ready_hold == 0) begin
			case ($urandom_range(0, 99)) inside
				[0:49]: begin
					out_ready  <= 1'b1;
					ready_hold <= int'($urandom_range(1, 30));
				end
				[50:74]: begin
					out_ready  <= 1'b0;
					ready_hold <= int'($urandom_range(1, 3));
				end
				[75:89]: begin
					out_ready  <= 1'b1;
					ready_hold <= int'($urandom_range(50, 200));
				end
				default: begin
					out_ready  <= 1'b0;
					ready_hold <= int'($urandom_range(10, 50));
				end
			endcase
		end else begin
			ready_hold <= ready_hold - 1;
		end
	end

	always @(posedge clk) begin
		pix_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting");
				mismatch_count++;
			end else begin
				w = pending_results.pop_front();
				check_field("motion", 64'(w.motion), 64'(motion));
				check_field("frame_done", 64'(w.done), 64'(frame_done));
				check_field("centroid_found", 64'(w.found), 64'(centroid_found));
				check_field("centroid_x", 64'(w.cx), 64'(centroid_x));
				check_field("centroid_y", 64'(w.cy), 64'(centroid_y));
				check_field("motion_total", 64'(w.total), 64'(motion_total));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		pix_req_t r;
		int       thr_val;
		int       min_val;
		int       len;
		int       phase_items;
		int       total_items;
		int       gap;
		bit       no_gaps;

		reset_motion_state();

		add_checked(px(0, 0, 0, 0, 0, 0, 0, 0, 0), rs(0, 0, 0, 0, 0, 0));
		add_checked(px(255, 255, 255, 0, 0, 0, 2047, 2047, 1), rs(1, 1, 0, 0, 0, 1));
		add_checked(px(0, 0, 0, 255, 255, 255, 0, 0, 1), rs(1, 1, 0, 0, 0, 1));
		add_write(fdmc_pkg::REG_COLOR_THRESHOLD, 0);
		add_write(fdmc_pkg::REG_MIN_MOTION, 0);
		add_checked(px(128, 128, 128, 128, 128, 128, 5, 5, 0), rs(0, 0, 0, 0, 0, 0));
		add_checked(px(1, 0, 0, 0, 0, 0, 0, 0, 0), rs(1, 0, 0, 0, 0, 0));
		add_pixel(px(0, 0, 0, 0, 0, 255, 2047, 2047, 1));
		add_checked(px(77, 77, 77, 77, 77, 77, 100, 100, 1), rs(0, 1, 0, 0, 0, 0));
		add_checked(px(0, 9, 0, 0, 0, 0, 2047, 1, 1), rs(1, 1, 1, 2047, 1, 1));
		add_write(fdmc_pkg::REG_COLOR_THRESHOLD, 3);
		add_write(fdmc_pkg::REG_MIN_MOTION, 1);
		add_checked(px(13, 40, 40, 10, 40, 40, 7, 7, 0), rs(0, 0, 0, 0, 0, 0));
		add_checked(px(13, 41, 40, 10, 40, 40, 100, 200, 0), rs(1, 0, 0, 0, 0, 0));
		add_checked(px(20, 20, 20, 20, 20, 20, 300, 300, 1), rs(0, 1, 0, 0, 0, 1));
		add_pixel(px(200, 0, 50, 0, 200, 50, 10, 5, 0));
		add_pixel(px(90, 90, 90, 80, 90, 90, 20, 6, 0));
		add_pixel(px(0, 0, 0, 0, 0, 100, 31, 8, 1));
		add_write(fdmc_pkg::REG_COLOR_THRESHOLD, THR_EXTREME);
		add_write(fdmc_pkg::REG_MIN_MOTION, MIN_EXTREME);
		add_checked(px(255, 255, 255, 0, 0, 0, 2047, 2047, 0), rs(0, 0, 0, 0, 0, 0));
		add_write(fdmc_pkg::REG_COLOR_THRESHOLD, 0);
		add_checked(px(255, 0, 255, 0, 255, 0, 1024, 1024, 1), rs(1, 1, 0, 0, 0, 1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(stim_table[i].idx, stim_table[i].data);
			end else begin
				drive_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
				gap = pick_gap();
				if (gap > 0)
					pause_sender(gap);
			end
		end

		total_items = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 0) begin
				thr_val = 0;
				min_val = 0;
			end else if (p == 1) begin
				thr_val = THR_EXTREME;
				min_val = MIN_EXTREME;
			end else begin
				case ($urandom_range(0, 3))
					0: thr_val = int'($urandom_range(0, 20));
					1: thr_val = int'($urandom_range(20, 120));
					2: thr_val = int'($urandom_range(100, 250));
					default: thr_val = int'($urandom_range(0, THR_EXTREME));
				endcase
				case ($urandom_range(0, 3))
					0: min_val = int'($urandom_range(0, 4));
					1: min_val = int'($urandom_range(0, 20));
					2: min_val = int'($urandom_range(0, 2));
					default: min_val = int'($urandom_range(0, MIN_EXTREME));
				endcase
			end
			wait_idle();
			write_reg(fdmc_pkg::REG_COLOR_THRESHOLD, fdmc_pkg::CFG_W'(thr_val));
			write_reg(fdmc_pkg::REG_MIN_MOTION, fdmc_pkg::CFG_W'(min_val));

			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(60, 200))
					: int'($urandom_range(1, 12));
				if (len > ITEMS_PER_PHASE - phase_items)
					len = ITEMS_PER_PHASE - phase_items;
				no_gaps = ($urandom_range(0, 9) < 3);
				for (int k = 0; k < len; k++) begin
					r = random_pixel(k == len - 1);
					drive_request(r, 1'b0, '0);
					phase_items++;
					total_items++;
					if (total_items % 250 == 0) begin
						wait_idle();
					end else if (!no_gaps) begin
						gap = pick_gap();
						if (gap > 0)
							pause_sender(gap);
					end
				end
			end
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/fdmc_pkg.sv
sv/fdmc_front.sv
sv/fdmc_queue.sv
sv/fdmc_back.sv
sv/frame_difference_motion_centroid_top.sv
sv/fdmc_checker.sv
verif/tb_top.sv
